FILE: rtl/core/tcfh_pkg.sv
// shared types and constants of the triangle coverage first hit unit
`default_nettype none

package tcfh_pkg;

   // field widths
   localparam int IN_W    = 11;   // vertex and offset fields at the ports
   localparam int COORD_W = 12;   // vertex with offset added
   localparam int GLYPH_W = 8;
   localparam int QUERY_W = 10;
   localparam int DIFF_W  = 13;   // coordinate differences
   localparam int PROD_W  = 26;   // one edge-function product
   localparam int EDGE_W  = 27;   // edge-function value

   // operation codes on req_operation
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 8'd32;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // depth of the command queue between front and back
   localparam int CMD_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_LOAD,
      CMD_QUERY,
      CMD_IGNORE
   } cmd_kind_type;

   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } point_type;

   typedef struct packed {
      cmd_kind_type        kind;
      point_type           a;
      point_type           b;
      point_type           c;
      logic [GLYPH_W-1:0]  glyph;
      logic [QUERY_W-1:0]  qx;
      logic [QUERY_W-1:0]  qy;
   } cmd_type;

   // stored triangle words
   localparam int AB_W = 2 * $bits(point_type);
   localparam int CG_W = $bits(point_type) + GLYPH_W;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_REPLY
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/tcfh_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module tcfh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tcfh_front.sv
// front end: decodes the operation and adds the offset to each vertex
`default_nettype none

module tcfh_front (
   input  wire logic [1:0]                      req_operation,
   input  wire logic signed [tcfh_pkg::IN_W-1:0] req_ax,
   input  wire logic signed [tcfh_pkg::IN_W-1:0] req_ay,
   input  wire logic signed [tcfh_pkg::IN_W-1:0] req_bx,
   input  wire logic signed [tcfh_pkg::IN_W-1:0] req_by,
   input  wire logic signed [tcfh_pkg::IN_W-1:0] req_cx,
   input  wire logic signed [tcfh_pkg::IN_W-1:0] req_cy,
   input  wire logic signed [tcfh_pkg::IN_W-1:0] req_offset_x,
   input  wire logic signed [tcfh_pkg::IN_W-1:0] req_offset_y,
   input  wire logic [tcfh_pkg::GLYPH_W-1:0]    req_glyph,
   input  wire logic [tcfh_pkg::QUERY_W-1:0]    req_query_x,
   input  wire logic [tcfh_pkg::QUERY_W-1:0]    req_query_y,
   output tcfh_pkg::cmd_type                    cmd
);

   // 11-bit plus 11-bit signed never leaves 12 bits
   function automatic logic [tcfh_pkg::COORD_W-1:0] place(
      input logic signed [tcfh_pkg::IN_W-1:0] v,
      input logic signed [tcfh_pkg::IN_W-1:0] o
   );
      logic signed [tcfh_pkg::COORD_W-1:0] s;
      s = tcfh_pkg::COORD_W'(v) + tcfh_pkg::COORD_W'(o);
      return s;
   endfunction

   always_comb begin
      unique case (req_operation)
         tcfh_pkg::OP_CLEAR: cmd.kind = tcfh_pkg::CMD_CLEAR;
         tcfh_pkg::OP_LOAD:  cmd.kind = tcfh_pkg::CMD_LOAD;
         tcfh_pkg::OP_QUERY: cmd.kind = tcfh_pkg::CMD_QUERY;
         default:            cmd.kind = tcfh_pkg::CMD_IGNORE;
      endcase
      cmd.a.x   = place(req_ax, req_offset_x);
      cmd.a.y   = place(req_ay, req_offset_y);
      cmd.b.x   = place(req_bx, req_offset_x);
      cmd.b.y   = place(req_by, req_offset_y);
      cmd.c.x   = place(req_cx, req_offset_x);
      cmd.c.y   = place(req_cy, req_offset_y);
      cmd.glyph = req_glyph;
      cmd.qx    = req_query_x;
      cmd.qy    = req_query_y;
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcfh_cmd_queue.sv
// short command queue between front and back
`default_nettype none

module tcfh_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire tcfh_pkg::cmd_type wr_data,
   input  wire logic              pop,
   output logic                   empty,
   output tcfh_pkg::cmd_type      rd_data
);

   localparam int DEPTH = tcfh_pkg::CMD_QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   tcfh_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] level_ff, level_in;
   logic          do_push, do_pop;

   assign full    = (level_ff == CW'(DEPTH));
   assign empty   = (level_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcfh_back.sv
// back end: table update, first-hit scan pipeline and result register
`default_nettype none

module tcfh_back #(
   parameter int MAX_TRIANGLES = 64,
   localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1,
   localparam int CNT_W = $clog2(MAX_TRIANGLES + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // command queue side
   input  wire logic                          cmd_valid,
   input  wire tcfh_pkg::cmd_type             cmd,
   output logic                               cmd_pop,
   // triangle memories
   output logic                               tab_we,
   output logic [IDX_W-1:0]                   tab_waddr,
   output logic [tcfh_pkg::AB_W-1:0]          tab_wdata_ab,
   output logic [tcfh_pkg::CG_W-1:0]          tab_wdata_cg,
   output logic                               tab_re,
   output logic [IDX_W-1:0]                   tab_raddr,
   input  wire logic [tcfh_pkg::AB_W-1:0]     tab_rdata_ab,
   input  wire logic [tcfh_pkg::CG_W-1:0]     tab_rdata_cg,
   // result side
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [tcfh_pkg::GLYPH_W-1:0]       rsp_pixel_glyph,
   output logic                               rsp_covered,
   output logic                               rsp_status
);

   localparam int DW = tcfh_pkg::DIFF_W;
   localparam int PW = tcfh_pkg::PROD_W;
   localparam int EW = tcfh_pkg::EDGE_W;
   localparam int GW = tcfh_pkg::GLYPH_W;

   tcfh_pkg::back_state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic [tcfh_pkg::QUERY_W-1:0] qx_ff, qy_ff;
   logic             found_ff, found_in;
   logic [GW-1:0]    found_glyph_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0] rsp_glyph_ff;
   logic rsp_covered_ff, rsp_status_ff;

   logic out_free, table_full, keep;
   logic start_scan, simple_reply, scan_reply, issue_en;
   logic hit_now, miss_done, covers;

   // pipeline valids
   logic s1_v_ff, s2_v_ff, s3_v_ff;

   // stage 2: differences
   logic signed [DW-1:0] dxab_ff, dyab_ff, dxbc_ff, dybc_ff, dxca_ff, dyca_ff;
   logic signed [DW-1:0] pxa_ff, pya_ff, pxb_ff, pyb_ff, pxc_ff, pyc_ff;
   logic signed [DW-1:0] cxa_ff, cya_ff;
   logic [GW-1:0]        s2_glyph_ff;

   // stage 3: products
   logic signed [PW-1:0] p0a_ff, p0b_ff, p1a_ff, p1b_ff, p2a_ff, p2b_ff;
   logic signed [PW-1:0] ara_ff, arb_ff;
   logic [GW-1:0]        s3_glyph_ff;

   tcfh_pkg::point_type  ra, rb, rc;
   logic signed [DW-1:0] ax, ay, bx, by, cx, cy, px, py;
   logic signed [EW-1:0] e0, e1, e2, area;

   assign out_free   = !rsp_valid_ff || rsp_pop;
   assign table_full = (count_ff >= CNT_W'(MAX_TRIANGLES));
   assign keep       = (state_ff == tcfh_pkg::BK_SCAN) && !hit_now;

   // ---------------- control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcfh_pkg::BK_IDLE: begin
            if (cmd_valid && cmd.kind == tcfh_pkg::CMD_QUERY) begin
               state_in = tcfh_pkg::BK_SCAN;
            end
         end
         tcfh_pkg::BK_SCAN: begin
            if (hit_now || miss_done) begin
               state_in = tcfh_pkg::BK_REPLY;
            end
         end
         tcfh_pkg::BK_REPLY: begin
            if (out_free) begin
               state_in = tcfh_pkg::BK_IDLE;
            end
         end
         default: state_in = tcfh_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop      = 1'b0;
      start_scan   = 1'b0;
      simple_reply = 1'b0;
      scan_reply   = 1'b0;
      issue_en     = 1'b0;
      unique case (state_ff)
         tcfh_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == tcfh_pkg::CMD_QUERY) begin
                  cmd_pop    = 1'b1;
                  start_scan = 1'b1;
               end else if (out_free) begin
                  cmd_pop      = 1'b1;
                  simple_reply = 1'b1;
               end
            end
         end
         tcfh_pkg::BK_SCAN: begin
            issue_en = !hit_now && (issue_ff < count_ff);
         end
         tcfh_pkg::BK_REPLY: begin
            scan_reply = out_free;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   assign miss_done = (state_ff == tcfh_pkg::BK_SCAN) && (issue_ff == count_ff) &&
                      !s1_v_ff && !s2_v_ff && !s3_v_ff;

   // ---------------- table write
   assign tab_we       = simple_reply && (cmd.kind == tcfh_pkg::CMD_LOAD) && !table_full;
   assign tab_waddr    = count_ff[IDX_W-1:0];
   assign tab_wdata_ab = {cmd.b, cmd.a};
   assign tab_wdata_cg = {cmd.glyph, cmd.c};
   assign tab_re       = issue_en;
   assign tab_raddr    = issue_ff[IDX_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (simple_reply && cmd.kind == tcfh_pkg::CMD_CLEAR) begin
         count_in = '0;
      end else if (tab_we) begin
         count_in = count_ff + 1'b1;
      end
      issue_in = issue_ff;
      if (start_scan) begin
         issue_in = '0;
      end else if (issue_en) begin
         issue_in = issue_ff + 1'b1;
      end
      found_in = found_ff;
      if (start_scan) begin
         found_in = 1'b0;
      end else if (hit_now) begin
         found_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (simple_reply || scan_reply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcfh_pkg::BK_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_v_ff      <= issue_en;
         s2_v_ff      <= s1_v_ff && keep;
         s3_v_ff      <= s2_v_ff && keep;
      end
   end

   // ---------------- scan pipeline
   assign ra = tab_rdata_ab[$bits(tcfh_pkg::point_type)-1:0];
   assign rb = tab_rdata_ab[tcfh_pkg::AB_W-1:$bits(tcfh_pkg::point_type)];
   assign rc = tab_rdata_cg[$bits(tcfh_pkg::point_type)-1:0];

   assign ax = DW'($signed(ra.x));
   assign ay = DW'($signed(ra.y));
   assign bx = DW'($signed(rb.x));
   assign by = DW'($signed(rb.y));
   assign cx = DW'($signed(rc.x));
   assign cy = DW'($signed(rc.y));
   assign px = $signed({{(DW - tcfh_pkg::QUERY_W){1'b0}}, qx_ff});
   assign py = $signed({{(DW - tcfh_pkg::QUERY_W){1'b0}}, qy_ff});

   always_ff @(posedge clock) begin
      if (start_scan) begin
         qx_ff <= cmd.qx;
         qy_ff <= cmd.qy;
      end
      if (hit_now) begin
         found_glyph_ff <= s3_glyph_ff;
      end
      // differences
      dxab_ff     <= bx - ax;
      dyab_ff     <= by - ay;
      dxbc_ff     <= cx - bx;
      dybc_ff     <= cy - by;
      dxca_ff     <= ax - cx;
      dyca_ff     <= ay - cy;
      pxa_ff      <= px - ax;
      pya_ff      <= py - ay;
      pxb_ff      <= px - bx;
      pyb_ff      <= py - by;
      pxc_ff      <= px - cx;
      pyc_ff      <= py - cy;
      cxa_ff      <= cx - ax;
      cya_ff      <= cy - ay;
      s2_glyph_ff <= tab_rdata_cg[tcfh_pkg::CG_W-1:$bits(tcfh_pkg::point_type)];
      // products
      p0a_ff      <= dxab_ff * pya_ff;
      p0b_ff      <= dyab_ff * pxa_ff;
      p1a_ff      <= dxbc_ff * pyb_ff;
      p1b_ff      <= dybc_ff * pxb_ff;
      p2a_ff      <= dxca_ff * pyc_ff;
      p2b_ff      <= dyca_ff * pxc_ff;
      ara_ff      <= dxab_ff * cya_ff;
      arb_ff      <= dyab_ff * cxa_ff;
      s3_glyph_ff <= s2_glyph_ff;
   end

   // edge functions and the inside test, edges included
   assign e0   = EW'(p0a_ff) - EW'(p0b_ff);
   assign e1   = EW'(p1a_ff) - EW'(p1b_ff);
   assign e2   = EW'(p2a_ff) - EW'(p2b_ff);
   assign area = EW'(ara_ff) - EW'(arb_ff);

   assign covers = ((area > 0) && (e0 >= 0) && (e1 >= 0) && (e2 >= 0)) ||
                   ((area < 0) && (e0 <= 0) && (e1 <= 0) && (e2 <= 0));
   assign hit_now = s3_v_ff && (state_ff == tcfh_pkg::BK_SCAN) && covers;

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (simple_reply) begin
         rsp_glyph_ff   <= tcfh_pkg::SPACE_GLYPH;
         rsp_covered_ff <= 1'b0;
         rsp_status_ff  <= (cmd.kind == tcfh_pkg::CMD_LOAD && table_full) ?
                           tcfh_pkg::STATUS_FULL : tcfh_pkg::STATUS_OK;
      end else if (scan_reply) begin
         rsp_glyph_ff   <= found_ff ? found_glyph_ff : tcfh_pkg::SPACE_GLYPH;
         rsp_covered_ff <= found_ff;
         rsp_status_ff  <= tcfh_pkg::STATUS_OK;
      end
   end

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_pixel_glyph = rsp_glyph_ff;
   assign rsp_covered     = rsp_covered_ff;
   assign rsp_status      = rsp_status_ff;

   // ---------------- checks
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TRIANGLES))
      else $error("triangle count beyond table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      tab_re |-> (state_ff == tcfh_pkg::BK_SCAN) && (issue_ff < count_ff))
      else $error("table read outside the filled entries");

   a_full_load_holds: assert property (@(posedge clock) disable iff (reset)
      (simple_reply && cmd.kind == tcfh_pkg::CMD_LOAD && table_full) |=>
      ($stable(count_ff) && rsp_status_ff == tcfh_pkg::STATUS_FULL))
      else $error("load into full table changed the table");

   a_hit_replies: assert property (@(posedge clock) disable iff (reset)
      hit_now |=> (state_ff == tcfh_pkg::BK_REPLY) && found_ff && !s1_v_ff && !s3_v_ff)
      else $error("hit did not end the scan");

endmodule

`default_nettype wire

FILE: rtl/core/triangle_coverage_first_hit_unit.sv
// top level of the triangle coverage first hit unit
`default_nettype none

// Keeps an ordered table of up to MAX_TRIANGLES triangles and answers pixel
// queries with the glyph of the first triangle, in load order, that covers
// the pixel (edges included, zero-area triangles cover nothing), or a space.
// Both sides look like queues: items go in with req_push while req_full is
// low, and each item gives exactly one result, held on the rsp_ ports while
// rsp_empty is low and taken with rsp_pop. A two-entry command queue sits
// between the front end (decode, offset add) and the back end, so new items
// are taken while the back end scans or a result waits. With an idle back
// end and a free result register, clear, load and unused codes go from the
// queue head straight into the result register. A query reads one stored
// triangle per cycle from the table memory into a three-stage edge-function
// pipeline; the scan ends at the first hit, or in a miss once all stored
// triangles have passed (an empty table gives a miss), and its answer waits
// for a free result register. The table memory needs no clearing after
// reset: only entries below the fill count are ever read.

module triangle_coverage_first_hit_unit #(
   parameter int MAX_TRIANGLES = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item side
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [1:0]                        req_operation,
   input  wire logic signed [tcfh_pkg::IN_W-1:0]  req_ax,
   input  wire logic signed [tcfh_pkg::IN_W-1:0]  req_ay,
   input  wire logic signed [tcfh_pkg::IN_W-1:0]  req_bx,
   input  wire logic signed [tcfh_pkg::IN_W-1:0]  req_by,
   input  wire logic signed [tcfh_pkg::IN_W-1:0]  req_cx,
   input  wire logic signed [tcfh_pkg::IN_W-1:0]  req_cy,
   input  wire logic signed [tcfh_pkg::IN_W-1:0]  req_offset_x,
   input  wire logic signed [tcfh_pkg::IN_W-1:0]  req_offset_y,
   input  wire logic [tcfh_pkg::GLYPH_W-1:0]      req_glyph,
   input  wire logic [tcfh_pkg::QUERY_W-1:0]      req_query_x,
   input  wire logic [tcfh_pkg::QUERY_W-1:0]      req_query_y,
   // result side
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [tcfh_pkg::GLYPH_W-1:0]           rsp_pixel_glyph,
   output logic                                   rsp_covered,
   output logic                                   rsp_status
);

   localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

   // decoded item from the front end, and the head of the command queue
   tcfh_pkg::cmd_type front_cmd;
   tcfh_pkg::cmd_type head_cmd;
   logic              queue_empty;
   logic              cmd_pop;

   // table memory ports
   logic                          tab_we;
   logic [IDX_W-1:0]              tab_waddr;
   logic [tcfh_pkg::AB_W-1:0]     tab_wdata_ab;
   logic [tcfh_pkg::CG_W-1:0]     tab_wdata_cg;
   logic                          tab_re;
   logic [IDX_W-1:0]              tab_raddr;
   logic [tcfh_pkg::AB_W-1:0]     tab_rdata_ab;
   logic [tcfh_pkg::CG_W-1:0]     tab_rdata_cg;

   // front end: classify the item and place the vertices
   tcfh_front u_front (
      .req_operation (req_operation),
      .req_ax        (req_ax),
      .req_ay        (req_ay),
      .req_bx        (req_bx),
      .req_by        (req_by),
      .req_cx        (req_cx),
      .req_cy        (req_cy),
      .req_offset_x  (req_offset_x),
      .req_offset_y  (req_offset_y),
      .req_glyph     (req_glyph),
      .req_query_x   (req_query_x),
      .req_query_y   (req_query_y),
      .cmd           (front_cmd)
   );

   // decoupling queue; its full flag is the item-side back-pressure
   tcfh_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data (front_cmd),
      .pop     (cmd_pop),
      .empty   (queue_empty),
      .rd_data (head_cmd)
   );

   // back end: table update, scan and result register
   tcfh_back #(
      .MAX_TRIANGLES (MAX_TRIANGLES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (!queue_empty),
      .cmd             (head_cmd),
      .cmd_pop         (cmd_pop),
      .tab_we          (tab_we),
      .tab_waddr       (tab_waddr),
      .tab_wdata_ab    (tab_wdata_ab),
      .tab_wdata_cg    (tab_wdata_cg),
      .tab_re          (tab_re),
      .tab_raddr       (tab_raddr),
      .tab_rdata_ab    (tab_rdata_ab),
      .tab_rdata_cg    (tab_rdata_cg),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_glyph (rsp_pixel_glyph),
      .rsp_covered     (rsp_covered),
      .rsp_status      (rsp_status)
   );

   // first two vertices of each triangle
   tcfh_ram #(
      .WIDTH (tcfh_pkg::AB_W),
      .DEPTH (MAX_TRIANGLES)
   ) u_tab_ab (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata_ab),
      .rd_en   (tab_re),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata_ab)
   );

   // third vertex and glyph
   tcfh_ram #(
      .WIDTH (tcfh_pkg::CG_W),
      .DEPTH (MAX_TRIANGLES)
   ) u_tab_cg (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata_cg),
      .rd_en   (tab_re),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata_cg)
   );

endmodule

`default_nettype wire
